// ----- src/qatb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qatb_pkg
// Shared types and constants for the quoted argument tokenizer and batcher.
// ----------------------------------------------------------------------------
package qatb_pkg;

  localparam int MAX_WORDS = 10000;
  localparam logic [16:0] WORDS_LIMIT = 17'(MAX_WORDS - 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_WORDS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT      = 3'd4;

  localparam logic [23:0] RST_MAX_BYTES   = 24'd2093056;
  localparam logic [15:0] RST_FIXED_BYTES = 16'd10;
  localparam logic [7:0]  RST_FIXED_WORDS = 8'd1;
  localparam logic [15:0] RST_MAX_ARGS    = 16'd0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_SQ   = 2'd1;
  localparam logic [1:0] ERR_DQ   = 2'd2;
  localparam logic [1:0] ERR_BSL  = 2'd3;

  localparam logic [23:0] ARG_LEN_MAX = 24'hFFFFFF;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [23:0] max_bytes;
    logic [15:0] fixed_bytes;
    logic [7:0]  fixed_words;
    logic [15:0] max_args;
    logic        strict;
  } cfg_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        arg_end;
    logic [23:0] arg_length;
    logic        dropped;
    logic [1:0]  error_code;
    logic        last;
  } evt_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        arg_end;
    logic [23:0] arg_length;
    logic        run_before;
    logic        run_after;
    logic        dropped;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

endpackage

// ----- src/quoted_arg_tokenizer_batcher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_arg_tokenizer_batcher_top
// Splits a byte stream into shell-style arguments and marks batch boundaries.
// Path: an accepted word is written into the event queue, then into the output register.
// Throughput: one input word per cycle while the event queue is not full.
// Reset (synchronous, rst high): lexer, batch counts, queue and output clear;
// configuration returns to defaults. After end of input or a fatal argument
// all further input words are taken and give no result until reset.
// ----------------------------------------------------------------------------
module quoted_arg_tokenizer_batcher_top #(
  parameter int LEN_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // in_byte
  input  logic                          s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // byte_valid, out_byte, arg_end, arg_length, run_before, run_after,
  // dropped, error_code, zero pad
  output logic [39:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,  // last
  input  logic                          cfg_we,
  input  logic [qatb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qatb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qatb_pkg::*;

  cfg_t cfg;
  evt_t f_evt, q_evt;
  res_t res;
  logic f_push, q_full, q_nonempty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_bytes   <= RST_MAX_BYTES;
      cfg.fixed_bytes <= RST_FIXED_BYTES;
      cfg.fixed_words <= RST_FIXED_WORDS;
      cfg.max_args    <= RST_MAX_ARGS;
      cfg.strict      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BYTES:   cfg.max_bytes   <= cfg_data;
        CFG_FIXED_BYTES: cfg.fixed_bytes <= cfg_data[15:0];
        CFG_FIXED_WORDS: cfg.fixed_words <= cfg_data[7:0];
        CFG_MAX_ARGS:    cfg.max_args    <= cfg_data[15:0];
        CFG_STRICT:      cfg.strict      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  qatb_front #(
    .LEN_BITS(LEN_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .q_full   (q_full),
    .push     (f_push),
    .evt      (f_evt)
  );

  qatb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .wdata    (f_evt),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_evt)
  );

  qatb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_data     (q_evt),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = {1'b0, res.error_code, res.dropped, res.run_after, res.run_before,
                         res.arg_length, res.arg_end, res.out_byte, res.byte_valid};
  assign m_axis_tlast = res.last;

endmodule

// ----- src/qatb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qatb_front
// Lexer: tracks quoting and escapes, counts argument length, flags oversize
// and fatal arguments, and pushes one event word per result into the queue.
// ----------------------------------------------------------------------------
module qatb_front #(
  parameter int LEN_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  qatb_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_op,
  input  logic [7:0]     in_byte,
  input  logic           q_full,
  output logic           push,
  output qatb_pkg::evt_t evt
);
  import qatb_pkg::*;

  localparam logic [2:0] M_BETWEEN = 3'd0;
  localparam logic [2:0] M_WORD    = 3'd1;
  localparam logic [2:0] M_SQ      = 3'd2;
  localparam logic [2:0] M_DQ      = 3'd3;
  localparam logic [2:0] M_ESC     = 3'd4;

  localparam int CW = (LEN_BITS + 2 > 26) ? LEN_BITS + 2 : 26;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  logic [2:0]          mode, mode_next;
  logic [LEN_BITS-1:0] cur_len, cur_len_next;
  logic                halted, halted_next;

  logic                accept, is_ws, fin, emit;
  logic [LEN_BITS:0]   need;
  logic [CW-1:0]       need_x, sum_x, max_x;
  logic                fatal, oversize;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_ws    = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_LF);

  assign need     = {1'b0, cur_len} + {{LEN_BITS{1'b0}}, 1'b1};
  assign need_x   = CW'(need);
  assign max_x    = CW'(cfg.max_bytes);
  assign sum_x    = CW'(cfg.fixed_bytes) + need_x;
  assign fatal    = cfg.strict && (need_x > max_x);
  assign oversize = fatal || (sum_x > max_x) || ({9'b0, cfg.fixed_words} >= WORDS_LIMIT);

  always_comb begin
    mode_next    = mode;
    cur_len_next = cur_len;
    halted_next  = halted;
    push         = 1'b0;
    evt          = '0;
    fin          = 1'b0;
    emit         = 1'b0;
    if (accept && !halted) begin
      if (in_op) begin
        push        = 1'b1;
        evt.last    = 1'b1;
        halted_next = 1'b1;
        unique case (mode)
          M_SQ:    evt.error_code = ERR_SQ;
          M_DQ:    evt.error_code = ERR_DQ;
          M_WORD:  fin = 1'b1;
          M_BETWEEN: ;
          default: evt.error_code = ERR_BSL;
        endcase
      end else begin
        unique case (mode)
          M_BETWEEN, M_WORD: begin
            if (is_ws) begin
              fin = (mode == M_WORD);
            end else if (in_byte == CH_SQ) begin
              mode_next = M_SQ;
            end else if (in_byte == CH_DQ) begin
              mode_next = M_DQ;
            end else if (in_byte == CH_BSL) begin
              mode_next = M_ESC;
            end else begin
              mode_next = M_WORD;
              emit      = 1'b1;
            end
          end
          M_SQ, M_DQ: begin
            if (in_byte == ((mode == M_SQ) ? CH_SQ : CH_DQ)) begin
              mode_next = M_WORD;
            end else if (in_byte != CH_LF) begin
              emit = 1'b1;
            end
          end
          default: begin
            mode_next = M_WORD;
            emit      = 1'b1;
          end
        endcase
      end
      if (emit) begin
        push           = 1'b1;
        evt.byte_valid = 1'b1;
        evt.out_byte   = in_byte;
        cur_len_next   = (cur_len == LEN_MAX) ? cur_len : cur_len + 1'b1;
      end
      if (fin) begin
        push           = 1'b1;
        evt.arg_end    = 1'b1;
        evt.arg_length = (CW'(cur_len) > CW'(ARG_LEN_MAX)) ? ARG_LEN_MAX : 24'(CW'(cur_len));
        evt.dropped    = oversize;
        cur_len_next   = '0;
        mode_next      = M_BETWEEN;
        if (fatal) begin
          evt.last    = 1'b1;
          halted_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_BETWEEN;
      cur_len <= '0;
      halted  <= 1'b0;
    end else begin
      mode    <= mode_next;
      cur_len <= cur_len_next;
      halted  <= halted_next;
    end
  end

endmodule

// ----- src/qatb_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qatb_fifo
// Two-entry event queue between the lexer and the batch decision stage.
// ----------------------------------------------------------------------------
module qatb_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qatb_pkg::evt_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output qatb_pkg::evt_t rdata
);
  import qatb_pkg::*;

  evt_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/qatb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qatb_back
// Batch decision stage: keeps batch byte and word counts, decides run
// before/after for each completed argument, and holds the output register.
// ----------------------------------------------------------------------------
module qatb_back (
  input  logic           clk,
  input  logic           rst,
  input  qatb_pkg::cfg_t cfg,
  input  logic           q_nonempty,
  input  qatb_pkg::evt_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output qatb_pkg::res_t res
);
  import qatb_pkg::*;

  logic [23:0] batch_bytes;
  logic [15:0] batch_args;

  logic [24:0] need;
  logic [23:0] cur_bytes, base_bytes, new_bytes;
  logic [25:0] sum_bytes;
  logic [16:0] words;
  logic [15:0] base_args, new_args;
  logic        run_b, run_a, decide;

  assign q_pop     = q_nonempty && (!out_valid || out_ready);
  assign decide    = q_data.arg_end && !q_data.dropped;

  assign need      = {1'b0, q_data.arg_length} + 25'd1;
  assign cur_bytes = (batch_args == '0) ? {8'b0, cfg.fixed_bytes} : batch_bytes;
  assign sum_bytes = {2'b0, cur_bytes} + {1'b0, need};
  assign words     = {9'b0, cfg.fixed_words} + {1'b0, batch_args};
  assign run_b     = (sum_bytes > {2'b0, cfg.max_bytes}) || (words >= WORDS_LIMIT);
  assign base_bytes = run_b ? {8'b0, cfg.fixed_bytes} : cur_bytes;
  assign base_args  = run_b ? 16'd0 : batch_args;
  assign new_bytes  = base_bytes + need[23:0];
  assign new_args   = base_args + 16'd1;
  assign run_a      = (cfg.max_args != '0) && (new_args >= cfg.max_args);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.byte_valid <= q_data.byte_valid;
      res.out_byte   <= q_data.out_byte;
      res.arg_end    <= q_data.arg_end;
      res.arg_length <= q_data.arg_length;
      res.run_before <= decide && run_b;
      res.run_after  <= decide && run_a;
      res.dropped    <= q_data.dropped;
      res.error_code <= q_data.error_code;
      res.last       <= q_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      batch_bytes <= '0;
      batch_args  <= '0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop && decide) begin
        batch_bytes <= new_bytes;
        batch_args  <= run_a ? 16'd0 : new_args;
      end
    end
  end

endmodule
